// ===== src/bounded_sigmoid_with_derivatives_assert.svh =====
// Assertion macros used by the checker file of the sigmoid unit.
`ifndef BOUNDED_SIGMOID_WITH_DERIVATIVES_ASSERT_SVH
`define BOUNDED_SIGMOID_WITH_DERIVATIVES_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BSD_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define BSD_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/bsd_pkg.sv =====
// Shared widths, codes, constants and the power-of-two table of the sigmoid unit.
package bsd_pkg;

    localparam int VALUE_W   = 32;
    localparam int VAR_W     = 5;
    localparam int CMD_W     = 2;
    localparam int CFG_IDX_W = 3;

    localparam int NUM_VARIABLES = 32;

    typedef enum logic [CMD_W-1:0] {
        CMD_VALUE  = 2'd0,
        CMD_FIRST  = 2'd1,
        CMD_SECOND = 2'd2,
        CMD_UNUSED = 2'd3
    } t_cmd;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SLOPE_GAIN = 3'd0,
        REG_MIDPOINT   = 3'd1,
        REG_FLOOR      = 3'd2,
        REG_CEILING    = 3'd3,
        REG_ACTIVE_VAR = 3'd4
    } t_reg_idx;

    localparam logic [VALUE_W-1:0] RST_SLOPE_GAIN = 32'd65536;
    localparam logic [VALUE_W-1:0] RST_MIDPOINT   = 32'd0;
    localparam logic [VALUE_W-1:0] RST_FLOOR      = 32'd0;
    localparam logic [VALUE_W-1:0] RST_CEILING    = 32'd65536;
    localparam logic [VAR_W-1:0]   RST_ACTIVE_VAR = 5'd0;

    localparam logic [31:0] INV_LN2_Q30 = 32'd1549082005;
    localparam logic [29:0] LN2_Q30     = 30'd744261118;
    localparam logic [30:0] ONE_Q30     = 31'h4000_0000;

    // Divider geometry: 62-bit dividend, 32-bit divisor.
    localparam int DIV_DW     = 62;
    localparam int DIV_VW     = 32;
    localparam int SIG_DIV_QW = 32;
    localparam int DER_DIV_QW = 30;

    // 2^(idx/16) in Q30.
    function automatic logic [30:0] pow2_frac(input logic [3:0] idx);
        logic [30:0] v;
        case (idx)
            4'd0:  v = 31'd1073741824;
            4'd1:  v = 31'd1121280436;
            4'd2:  v = 31'd1170923762;
            4'd3:  v = 31'd1222764986;
            4'd4:  v = 31'd1276901417;
            4'd5:  v = 31'd1333434673;
            4'd6:  v = 31'd1392470869;
            4'd7:  v = 31'd1454120821;
            4'd8:  v = 31'd1518500250;
            4'd9:  v = 31'd1585730000;
            4'd10: v = 31'd1655936265;
            4'd11: v = 31'd1729250827;
            4'd12: v = 31'd1805811302;
            4'd13: v = 31'd1885761398;
            4'd14: v = 31'd1969251188;
            default: v = 31'd2056437386;
        endcase
        return v;
    endfunction

endpackage

// ===== src/bsd_if.sv =====
// Channel interfaces of the sigmoid unit: item input, result output and register writes.
interface bsd_in_if;
    logic                                    valid;
    logic                                    ready;
    logic [bsd_pkg::CMD_W-1:0]               command;
    logic signed [bsd_pkg::VALUE_W-1:0]      x_value;
    logic [bsd_pkg::VAR_W-1:0]               first_variable;
    logic [bsd_pkg::VAR_W-1:0]               second_variable;

    modport source(output valid, command, x_value, first_variable, second_variable,
                   input ready);
    modport sink(input valid, command, x_value, first_variable, second_variable,
                 output ready);
endinterface

interface bsd_out_if;
    logic                                    valid;
    logic                                    ready;
    logic signed [bsd_pkg::VALUE_W-1:0]      result_value;
    logic                                    saturated;
    logic                                    config_error;

    modport source(output valid, result_value, saturated, config_error, input ready);
    modport sink(input valid, result_value, saturated, config_error, output ready);
endinterface

interface bsd_cfg_if;
    logic                                    valid;
    logic                                    ready;
    logic [bsd_pkg::CFG_IDX_W-1:0]           index;
    logic [bsd_pkg::VALUE_W-1:0]             data;

    modport source(output valid, index, data, input ready);
    modport sink(input valid, index, data, output ready);
endinterface

// ===== src/bsd_div.sv =====
// Pipelined restoring divider: one quotient bit per register stage, context carried along.
module bsd_div #(
    parameter int DW = bsd_pkg::DIV_DW,
    parameter int VW = bsd_pkg::DIV_VW,
    parameter int QW = bsd_pkg::SIG_DIV_QW,
    parameter type t_ctx = logic
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  logic [DW-1:0] i_dividend,
    input  logic [VW-1:0] i_divisor,
    input  t_ctx          i_ctx,
    output logic          o_valid,
    output logic [QW-1:0] o_quot,
    output logic          o_rem_nz,
    output t_ctx          o_ctx
);

    // The upper dividend bits must already be below the divisor, so QW steps suffice.
    logic          r_vld [QW];
    logic [VW-1:0] r_rem [QW];
    logic [QW-1:0] r_quo [QW];
    logic [VW-1:0] r_dv  [QW];
    t_ctx          r_ctx [QW];

    for (genvar s = 0; s < QW; s++) begin : g_step
        logic          w_vld_in;
        logic [VW-1:0] w_rem_in;
        logic [QW-1:0] w_quo_in;
        logic [VW-1:0] w_dv_in;
        t_ctx          w_ctx_in;
        logic [VW:0]   w_trial;
        logic          w_fits;

        if (s == 0) begin : g_first
            assign w_vld_in = i_valid;
            assign w_rem_in = VW'(i_dividend[DW-1:QW]);
            assign w_quo_in = i_dividend[QW-1:0];
            assign w_dv_in  = i_divisor;
            assign w_ctx_in = i_ctx;
        end else begin : g_next
            assign w_vld_in = r_vld[s-1];
            assign w_rem_in = r_rem[s-1];
            assign w_quo_in = r_quo[s-1];
            assign w_dv_in  = r_dv[s-1];
            assign w_ctx_in = r_ctx[s-1];
        end

        assign w_trial = {w_rem_in, w_quo_in[QW-1]};
        assign w_fits  = w_trial >= {1'b0, w_dv_in};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s] <= 1'b0;
            end else if (i_en) begin
                r_vld[s] <= w_vld_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s] <= w_fits ? VW'(w_trial - {1'b0, w_dv_in}) : w_trial[VW-1:0];
                r_quo[s] <= {w_quo_in[QW-2:0], w_fits};
                r_dv[s]  <= w_dv_in;
                r_ctx[s] <= w_ctx_in;
            end
        end
    end

    assign o_valid  = r_vld[QW-1];
    assign o_quot   = r_quo[QW-1];
    assign o_rem_nz = |r_rem[QW-1];
    assign o_ctx    = r_ctx[QW-1];

endmodule

// ===== src/bounded_sigmoid_with_derivatives.sv =====
// Throughput: one item per cycle; three 30- to 32-stage divider pipelines set the depth.
// A stall at the output freezes the whole pipeline and a new item enters whenever it moves.
// Reset (synchronous, active low) clears all valid bits and loads the register defaults.
// Register writes take effect at once. The user must make them only while the pipeline
// is empty; the block itself does not enforce it.
module bounded_sigmoid_with_derivatives (
    input  logic      i_clk,
    input  logic      i_rst_n,
    bsd_in_if.sink    i_in,
    bsd_out_if.source o_out,
    bsd_cfg_if.sink   i_cfg
);

    typedef struct packed {
        logic [1:0]         cmd;
        logic [4:0]         v1;
        logic [4:0]         v2;
        logic               tail_lo;
        logic               tail_hi;
        logic signed [6:0]  n;
        logic [31:0]        fn;
        logic               zero;
        logic [31:0]        first;
        logic               fflag;
        logic               neg;
    } t_ctx;

    function automatic logic [32:0] sat32(input logic signed [63:0] v);
        logic [32:0] res;
        if (v > 64'sd2147483647) begin
            res = {1'b1, 32'h7FFF_FFFF};
        end else if (v < -64'sd2147483648) begin
            res = {1'b1, 32'h8000_0000};
        end else begin
            res = {1'b0, v[31:0]};
        end
        return res;
    endfunction

    // Configuration registers.
    logic signed [31:0] r_slope_gain;
    logic signed [31:0] r_midpoint;
    logic signed [31:0] r_floor;
    logic signed [31:0] r_ceiling;
    logic [4:0]         r_active_var;

    logic [31:0]        w_span;
    logic               w_bad;
    logic               w_adv;

    // Pipeline registers.
    logic r_v1, r_v2, r_v3, r_v4, r_v5, r_v6, r_v7, r_v8, r_v9;
    logic r_v10, r_v11, r_v12, r_v13, r_v14, r_v15, r_v16, r_v17;
    logic r_out_valid;

    t_ctx r1_ctx, r2_ctx, r3_ctx, r4_ctx, r5_ctx, r6_ctx, r7_ctx, r8_ctx, r9_ctx;
    t_ctx r10_ctx, r11_ctx, r12_ctx, r13_ctx, r14_ctx, r15_ctx, r16_ctx, r17_ctx;
    t_ctx n1_ctx, n3_ctx, n5_ctx, n10_ctx, n11_ctx, n13_ctx;

    logic signed [32:0] r1_d;
    logic signed [64:0] r2_kd;
    logic signed [22:0] r3_e;
    logic signed [55:0] r4_tp;
    logic [41:0]        r5_gl;
    logic [3:0]         r5_idx, r6_idx, r7_idx;
    logic [25:0]        r6_u;
    logic [51:0]        r6_uu;
    logic [30:0]        r7_p;
    logic [61:0]        r8_mp;
    logic [31:0]        r9_den;
    logic [61:0]        r11_pr;
    logic signed [62:0] r12_kp;
    logic signed [64:0] r12_qp;
    logic [61:0]        r13_mag;
    logic signed [30:0] r14_q;
    logic signed [62:0] r15_kq;
    logic signed [62:0] r16_hi;
    logic signed [48:0] r16_lo;
    logic [31:0]        r17_second;
    logic               r17_sflag;

    logic signed [31:0] r_out_result;
    logic               r_out_sat;
    logic               r_out_err;

    // Stage-local logic.
    logic signed [64:0] w_neg_kd;
    logic signed [48:0] w_e;
    logic [25:0]        w_u;
    logic [31:0]        w_m;
    logic [5:0]         w_amt;
    logic [31:0]        w_den;
    logic [31:0]        w_q;
    logic [63:0]        w_pr;
    logic signed [30:0] w_ps;
    logic signed [33:0] w_s;
    logic [32:0]        w_first;
    logic signed [64:0] w_mag;
    logic [30:0]        w_qpos;
    logic signed [30:0] w_qs;
    logic signed [30:0] w_ah;
    logic signed [16:0] w_al;
    logic signed [63:0] w_sum;
    logic [32:0]        w_second;
    logic               w_act1, w_act2;
    logic signed [31:0] n_out_result;
    logic               n_out_sat;
    logic               n_out_err;

    // Divider ports.
    logic        d1_valid, d2_valid, d3_valid;
    logic [31:0] d1_quot;
    logic [29:0] d2_quot, d3_quot;
    logic        d3_rem_nz;
    t_ctx        d1_ctx, d2_ctx, d3_ctx;

    assign w_span = r_ceiling - r_floor;
    assign w_bad  = r_floor >= r_ceiling;

    assign w_adv      = !r_out_valid || o_out.ready;
    assign i_in.ready = w_adv;
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slope_gain <= bsd_pkg::RST_SLOPE_GAIN;
            r_midpoint   <= bsd_pkg::RST_MIDPOINT;
            r_floor      <= bsd_pkg::RST_FLOOR;
            r_ceiling    <= bsd_pkg::RST_CEILING;
            r_active_var <= bsd_pkg::RST_ACTIVE_VAR;
        end else if (i_cfg.valid) begin
            unique case (bsd_pkg::t_reg_idx'(i_cfg.index))
                bsd_pkg::REG_SLOPE_GAIN: r_slope_gain <= i_cfg.data;
                bsd_pkg::REG_MIDPOINT:   r_midpoint   <= i_cfg.data;
                bsd_pkg::REG_FLOOR:      r_floor      <= i_cfg.data;
                bsd_pkg::REG_CEILING:    r_ceiling    <= i_cfg.data;
                bsd_pkg::REG_ACTIVE_VAR: r_active_var <= i_cfg.data[4:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;  r_v2 <= 1'b0;  r_v3 <= 1'b0;  r_v4 <= 1'b0;
            r_v5 <= 1'b0;  r_v6 <= 1'b0;  r_v7 <= 1'b0;  r_v8 <= 1'b0;
            r_v9 <= 1'b0;  r_v10 <= 1'b0; r_v11 <= 1'b0; r_v12 <= 1'b0;
            r_v13 <= 1'b0; r_v14 <= 1'b0; r_v15 <= 1'b0; r_v16 <= 1'b0;
            r_v17 <= 1'b0; r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_v1  <= i_in.valid;
            r_v2  <= r_v1;
            r_v3  <= r_v2;
            r_v4  <= r_v3;
            r_v5  <= r_v4;
            r_v6  <= r_v5;
            r_v7  <= r_v6;
            r_v8  <= r_v7;
            r_v9  <= r_v8;
            r_v10 <= d1_valid;
            r_v11 <= r_v10;
            r_v12 <= d2_valid;
            r_v13 <= r_v12;
            r_v14 <= d3_valid;
            r_v15 <= r_v14;
            r_v16 <= r_v15;
            r_v17 <= r_v16;
            r_out_valid <= r_v17;
        end
    end

    // Front end: exponent, range reduction and the table-based power of two.
    always_comb begin
        n1_ctx     = '0;
        n1_ctx.cmd = i_in.command;
        n1_ctx.v1  = i_in.first_variable;
        n1_ctx.v2  = i_in.second_variable;
    end

    assign w_neg_kd = -r2_kd;
    assign w_e      = w_neg_kd[64:16];

    always_comb begin
        n3_ctx         = r2_ctx;
        n3_ctx.tail_lo = w_e > 49'sd2097152;
        n3_ctx.tail_hi = w_e < -49'sd2097152;
    end

    always_comb begin
        n5_ctx   = r4_ctx;
        n5_ctx.n = r4_tp[52:46];
    end

    assign w_u = r5_gl[41:16];

    // Denominator of the sigmoid quotient, scaled so that it stays within 32 bits.
    assign w_m   = r8_mp[61:30];
    assign w_amt = r8_ctx.n[6] ? 6'(-r8_ctx.n) : 6'(r8_ctx.n);
    assign w_den = r8_ctx.n[6] ? (32'(bsd_pkg::ONE_Q30) + (w_m >> w_amt))
                               : (w_m + (32'(bsd_pkg::ONE_Q30) >> w_amt));

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r1_d   <= {i_in.x_value[31], i_in.x_value} - {r_midpoint[31], r_midpoint};
            r1_ctx <= n1_ctx;
            r2_kd  <= r_slope_gain * r1_d;
            r2_ctx <= r1_ctx;
            r3_e   <= w_e[22:0];
            r3_ctx <= n3_ctx;
            r4_tp  <= r3_e * $signed({1'b0, bsd_pkg::INV_LN2_Q30});
            r4_ctx <= r3_ctx;
            r5_gl  <= r4_tp[41:30] * bsd_pkg::LN2_Q30;
            r5_idx <= r4_tp[45:42];
            r5_ctx <= n5_ctx;
            r6_u   <= w_u;
            r6_uu  <= w_u * w_u;
            r6_idx <= r5_idx;
            r6_ctx <= r5_ctx;
            r7_p   <= bsd_pkg::ONE_Q30 + 31'(r6_u) + 31'(r6_uu[51:31]);
            r7_idx <= r6_idx;
            r7_ctx <= r6_ctx;
            r8_mp  <= bsd_pkg::pow2_frac(r7_idx) * r7_p;
            r8_ctx <= r7_ctx;
            r9_den <= w_den;
            r9_ctx <= r8_ctx;
        end
    end

    bsd_div #(
        .DW(bsd_pkg::DIV_DW),
        .VW(bsd_pkg::DIV_VW),
        .QW(bsd_pkg::SIG_DIV_QW),
        .t_ctx(t_ctx)
    ) u_div_sig (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (w_adv),
        .i_valid    (r_v9),
        .i_dividend ({w_span, 30'd0}),
        .i_divisor  (r9_den),
        .i_ctx      (r9_ctx),
        .o_valid    (d1_valid),
        .o_quot     (d1_quot),
        .o_rem_nz   (),
        .o_ctx      (d1_ctx)
    );

    // Offset of the sigmoid above the floor; the tails pin it to a bound.
    assign w_q = d1_ctx.n[6] ? d1_quot : (d1_quot >> 6'(d1_ctx.n));

    always_comb begin
        n10_ctx = d1_ctx;
        if (d1_ctx.tail_lo) begin
            n10_ctx.fn = '0;
        end else if (d1_ctx.tail_hi) begin
            n10_ctx.fn = w_span;
        end else begin
            n10_ctx.fn = w_q;
        end
    end

    assign w_pr = 64'(r10_ctx.fn) * 64'(w_span - r10_ctx.fn);

    always_comb begin
        n11_ctx      = r10_ctx;
        n11_ctx.zero = (r10_ctx.fn == '0) || (r10_ctx.fn >= w_span);
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r10_ctx <= n10_ctx;
            r11_pr  <= w_pr[61:0];
            r11_ctx <= n11_ctx;
        end
    end

    bsd_div #(
        .DW(bsd_pkg::DIV_DW),
        .VW(bsd_pkg::DIV_VW),
        .QW(bsd_pkg::DER_DIV_QW),
        .t_ctx(t_ctx)
    ) u_div_p (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (w_adv),
        .i_valid    (r_v11),
        .i_dividend (r11_pr),
        .i_divisor  (w_span),
        .i_ctx      (r11_ctx),
        .o_valid    (d2_valid),
        .o_quot     (d2_quot),
        .o_rem_nz   (),
        .o_ctx      (d2_ctx)
    );

    // First derivative and the numerator of the second.
    assign w_ps    = $signed({1'b0, d2_quot});
    assign w_s     = $signed({2'b00, w_span}) - $signed({1'b0, d2_ctx.fn, 1'b0});
    assign w_first = sat32(64'($signed(r12_kp[62:16])));
    assign w_mag   = r12_qp[64] ? -r12_qp : r12_qp;

    always_comb begin
        n13_ctx       = r12_ctx;
        n13_ctx.first = w_first[31:0];
        n13_ctx.fflag = w_first[32];
        n13_ctx.neg   = r12_qp[64];
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r12_kp  <= r_slope_gain * w_ps;
            r12_qp  <= w_ps * w_s;
            r12_ctx <= d2_ctx;
            r13_mag <= w_mag[61:0];
            r13_ctx <= n13_ctx;
        end
    end

    bsd_div #(
        .DW(bsd_pkg::DIV_DW),
        .VW(bsd_pkg::DIV_VW),
        .QW(bsd_pkg::DER_DIV_QW),
        .t_ctx(t_ctx)
    ) u_div_q (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (w_adv),
        .i_valid    (r_v13),
        .i_dividend (r13_mag),
        .i_divisor  (w_span),
        .i_ctx      (r13_ctx),
        .o_valid    (d3_valid),
        .o_quot     (d3_quot),
        .o_rem_nz   (d3_rem_nz),
        .o_ctx      (d3_ctx)
    );

    // Floor division of a negative numerator: -q when exact, otherwise -q - 1.
    assign w_qpos = {1'b0, d3_quot};
    assign w_qs   = d3_ctx.neg ? $signed(~w_qpos + 31'(!d3_rem_nz)) : $signed(w_qpos);

    // k*A is formed from two narrower products on the upper and lower halves of A.
    assign w_ah     = $signed(r15_kq[62:32]);
    assign w_al     = $signed({1'b0, r15_kq[31:16]});
    assign w_sum    = r16_hi + (r16_lo >>> 16);
    assign w_second = sat32(w_sum);

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r14_q      <= w_qs;
            r14_ctx    <= d3_ctx;
            r15_kq     <= r_slope_gain * r14_q;
            r15_ctx    <= r14_ctx;
            r16_hi     <= r_slope_gain * w_ah;
            r16_lo     <= r_slope_gain * w_al;
            r16_ctx    <= r15_ctx;
            r17_second <= w_second[31:0];
            r17_sflag  <= w_second[32];
            r17_ctx    <= r16_ctx;
        end
    end

    // Result selection.
    assign w_act1 = (r17_ctx.v1 == r_active_var)
                 && (9'(r17_ctx.v1) < 9'(bsd_pkg::NUM_VARIABLES))
                 && (9'(r_active_var) < 9'(bsd_pkg::NUM_VARIABLES));
    assign w_act2 = (r17_ctx.v2 == r_active_var)
                 && (9'(r17_ctx.v2) < 9'(bsd_pkg::NUM_VARIABLES))
                 && (9'(r_active_var) < 9'(bsd_pkg::NUM_VARIABLES));

    always_comb begin
        n_out_result = '0;
        n_out_sat    = 1'b0;
        n_out_err    = 1'b0;
        if (w_bad) begin
            n_out_err = 1'b1;
        end else begin
            case (bsd_pkg::t_cmd'(r17_ctx.cmd))
                bsd_pkg::CMD_VALUE: begin
                    n_out_result = r_floor + r17_ctx.fn;
                    n_out_sat    = r17_ctx.tail_lo || r17_ctx.tail_hi;
                end
                bsd_pkg::CMD_UNUSED: begin
                    n_out_sat = 1'b1;
                end
                default: begin
                    if (!w_act1 || (r17_ctx.cmd == bsd_pkg::CMD_SECOND && !w_act2)
                        || r17_ctx.zero) begin
                        n_out_sat = 1'b1;
                    end else if (r17_ctx.cmd == bsd_pkg::CMD_FIRST) begin
                        n_out_result = r17_ctx.first;
                        n_out_sat    = r17_ctx.fflag;
                    end else begin
                        n_out_result = r17_second;
                        n_out_sat    = r17_sflag;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_result <= n_out_result;
            r_out_sat    <= n_out_sat;
            r_out_err    <= n_out_err;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.result_value = r_out_result;
    assign o_out.saturated    = r_out_sat;
    assign o_out.config_error = r_out_err;

endmodule

// ===== src/bsd_checker.sv =====
// Port-level checks of the sigmoid unit and their attachment to the top level.
`include "bounded_sigmoid_with_derivatives_assert.svh"

module bsd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [31:0] i_result_value,
    input logic        i_saturated,
    input logic        i_config_error
);

    // A waiting result must not block the input unless the output is stalled.
    `BSD_ASSERT_IMP(a_in_ready, i_clk, i_rst_n, !i_out_valid || i_out_ready, i_in_ready, "input stalled while output moves")

    `BSD_ASSERT_IMP(a_err_zero, i_clk, i_rst_n, i_out_valid && i_config_error, (i_result_value == 32'd0) && !i_saturated, "bad bounds result not zero")

    `BSD_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid, "stalled result dropped")

    `BSD_ASSERT_NXT(a_out_stable, i_clk, i_rst_n, i_out_valid && !i_out_ready, $stable(i_result_value) && $stable(i_saturated) && $stable(i_config_error), "stalled result changed")

endmodule

bind bounded_sigmoid_with_derivatives bsd_checker u_bsd_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in.valid),
    .i_in_ready     (i_in.ready),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_result_value (o_out.result_value),
    .i_saturated    (o_out.saturated),
    .i_config_error (o_out.config_error)
);
